### sv/bram_map_pkg.sv
// Shared types and constants for the banked RAM map allocator.
// Used by the channel interfaces and the top level; depends on nothing.
package bram_map_pkg;

   // Field widths of the channels
   localparam int OP_W   = 2;
   localparam int ADDR_W = 9;
   localparam int SIZE_W = 4;

   // Width of base + mirror + offset sums (holds 511 + 511 + 15)
   localparam int CALC_W = 11;

   // Operation codes
   localparam logic [OP_W-1:0] OP_ADD_RANGE = 2'd0;
   localparam logic [OP_W-1:0] OP_ASSIGN_FIXED = 2'd1;
   localparam logic [OP_W-1:0] OP_ASSIGN_RELOC = 2'd2;
   localparam logic [OP_W-1:0] OP_QUERY_SPECIAL = 2'd3;

   // One map entry as held in the map RAM
   typedef struct packed {
      logic              valid;
      logic              special;
      logic [ADDR_W-1:0] amask;
      logic              owned;
   } map_entry_type;

endpackage

### sv/bram_map_if.sv
// Valid/ready channel interfaces for the banked RAM map allocator.
// Depends on bram_map_pkg for field widths.

// Request channel: one operation per item
interface bram_map_req_if;
   logic                              valid;
   logic                              ready;
   logic [bram_map_pkg::OP_W-1:0]     op;
   logic [bram_map_pkg::ADDR_W-1:0]   first_addr;
   logic [bram_map_pkg::ADDR_W-1:0]   last_addr;
   logic [bram_map_pkg::ADDR_W-1:0]   alias_mask;
   logic                              special_flag;
   logic [bram_map_pkg::SIZE_W-1:0]   size;

   modport source (output valid, op, first_addr, last_addr, alias_mask,
                   special_flag, size, input ready);
   modport sink   (input valid, op, first_addr, last_addr, alias_mask,
                   special_flag, size, output ready);
endinterface

// Response channel: one result item per request
interface bram_map_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              status;
   logic [bram_map_pkg::ADDR_W-1:0]   result_address;
   logic                              is_special;
   logic [bram_map_pkg::ADDR_W-1:0]   mapped_alias;

   modport source (output valid, status, result_address, is_special, mapped_alias,
                   input ready);
   modport sink   (input valid, status, result_address, is_special, mapped_alias,
                   output ready);
endinterface

// Register write channel: max_address
interface bram_map_csr_if;
   logic                              valid;
   logic                              ready;
   logic [bram_map_pkg::ADDR_W-1:0]   data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

### sv/banked_ram_map_allocator.sv
// Banked RAM map allocator: map RAM, sequencer and shared address unit.
// Depends on bram_map_pkg and the channel interfaces in bram_map_if.sv.

// After reset the map RAM is cleared one entry per cycle, all min(RAM_ENTRIES, 512)
// entries, during which no request item is taken (max_address writes still are).
// Every map access goes through the single map RAM port with a registered read,
// so each visited address takes a read state and then a write or check state.
// add_range visits each address in start..end per mirror mask (popcount(alias_mask)+1
// masks), skipping addresses past the limit. assign_fixed checks the run byte by
// byte, then marks each owned byte and mirror. assign_relocatable retries the run
// check at each base from the first address up to the limit, then does the marking
// pass. query reads one entry. One item is worked on at a time; a finished result
// waits in the output register while the next item is accepted.
module banked_ram_map_allocator #(
   parameter int RAM_ENTRIES    = 512,
   parameter int MAX_ALLOC_SIZE = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   bram_map_req_if.sink             req_chan,
   bram_map_rsp_if.source           rsp_chan,
   bram_map_csr_if.sink             csr_chan
);

   localparam int ADDR_W = bram_map_pkg::ADDR_W;
   localparam int SIZE_W = bram_map_pkg::SIZE_W;
   localparam int CALC_W = bram_map_pkg::CALC_W;

   // Addresses never exceed the 9-bit field range, so deeper maps are not stored
   localparam int MAP_DEPTH = (RAM_ENTRIES < (1 << ADDR_W)) ? RAM_ENTRIES : (1 << ADDR_W);
   localparam int MAP_AW    = $clog2(MAP_DEPTH);
   localparam logic [ADDR_W-1:0] TOP_ADDR = ADDR_W'(MAP_DEPTH - 1);
   localparam logic [MAP_AW-1:0] LAST_IDX = MAP_AW'(MAP_DEPTH - 1);

   // Sequencer states
   localparam logic [3:0] ST_CLEAR     = 4'd0;
   localparam logic [3:0] ST_IDLE      = 4'd1;
   localparam logic [3:0] ST_ADD_RD    = 4'd2;
   localparam logic [3:0] ST_ADD_WR    = 4'd3;
   localparam logic [3:0] ST_CHK_START = 4'd4;
   localparam logic [3:0] ST_CHK_RD    = 4'd5;
   localparam logic [3:0] ST_CHK_EV    = 4'd6;
   localparam logic [3:0] ST_SPC_EV    = 4'd7;
   localparam logic [3:0] ST_ALC_BASE  = 4'd8;
   localparam logic [3:0] ST_ALC_AM    = 4'd9;
   localparam logic [3:0] ST_ALC_RD    = 4'd10;
   localparam logic [3:0] ST_ALC_WR    = 4'd11;
   localparam logic [3:0] ST_QRY_EV    = 4'd12;
   localparam logic [3:0] ST_DONE      = 4'd13;

   // Control registers
   logic [3:0]        state_ff, state_in;
   logic [MAP_AW-1:0] clr_ff, clr_in;
   logic [ADDR_W-1:0] max_addr_ff, max_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Working registers of the current item
   logic [bram_map_pkg::OP_W-1:0] op_ff, op_in;
   logic [ADDR_W-1:0] sa_ff, sa_in;
   logic [ADDR_W-1:0] ea_ff, ea_in;
   logic [ADDR_W-1:0] am_ff, am_in;
   logic              sp_ff, sp_in;
   logic [SIZE_W-1:0] sz_ff, sz_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [ADDR_W-1:0] i_ff, i_in;
   logic [ADDR_W-1:0] m_ff, m_in;
   logic [SIZE_W-1:0] k_ff, k_in;
   logic [ADDR_W-1:0] amask_ff, amask_in;
   logic              res_status_ff, res_status_in;
   logic              res_isp_ff, res_isp_in;
   logic [ADDR_W-1:0] res_addr_ff, res_addr_in;
   logic [ADDR_W-1:0] res_alias_ff, res_alias_in;

   // Output register
   logic              rsp_status_ff, rsp_status_in;
   logic              rsp_isp_ff, rsp_isp_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [ADDR_W-1:0] rsp_alias_ff, rsp_alias_in;

   // Map RAM and its port
   bram_map_pkg::map_entry_type map_mem [MAP_DEPTH];
   bram_map_pkg::map_entry_type rdata_ff;
   bram_map_pkg::map_entry_type wr_data;
   logic              rd_en, wr_en;
   logic [MAP_AW-1:0] rd_idx, wr_idx;

   // Helpers
   logic [ADDR_W-1:0] lim;
   logic [CALC_W-1:0] lim_w;
   logic [ADDR_W-1:0] or_addr;
   logic [CALC_W-1:0] sum_b, sum_c, addr_sum;
   logic              req_fire, req_size_ok;
   logic              add_next, alc_next;

   assign lim      = (max_addr_ff < TOP_ADDR) ? max_addr_ff : TOP_ADDR;
   assign lim_w    = CALC_W'(lim);
   assign or_addr  = i_ff | m_ff;
   assign req_fire = req_chan.valid && req_chan.ready;
   assign req_size_ok = (req_chan.size != '0) &&
                        (32'(req_chan.size) <= 32'(MAX_ALLOC_SIZE));

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.result_address = rsp_addr_ff;
   assign rsp_chan.is_special     = rsp_isp_ff;
   assign rsp_chan.mapped_alias   = rsp_alias_ff;

   // Shared address unit: base + operand + offset, operands picked by state
   always_comb begin
      sum_b = '0;
      sum_c = '0;
      unique case (state_ff)
         ST_CHK_START: sum_b = CALC_W'(sz_ff - SIZE_W'(1));
         ST_CHK_RD:    sum_b = CALC_W'(k_ff);
         ST_ALC_RD, ST_ALC_WR: begin
            sum_b = CALC_W'(m_ff);
            sum_c = CALC_W'(k_ff);
         end
         default: sum_b = '0;
      endcase
   end
   assign addr_sum = CALC_W'(base_ff) + sum_b + sum_c;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      op_in         = op_ff;
      sa_in         = sa_ff;
      ea_in         = ea_ff;
      am_in         = am_ff;
      sp_in         = sp_ff;
      sz_in         = sz_ff;
      base_in       = base_ff;
      i_in          = i_ff;
      m_in          = m_ff;
      k_in          = k_ff;
      amask_in      = amask_ff;
      res_status_in = res_status_ff;
      res_isp_in    = res_isp_ff;
      res_addr_in   = res_addr_ff;
      res_alias_in  = res_alias_ff;
      rsp_status_in = rsp_status_ff;
      rsp_isp_in    = rsp_isp_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_alias_in  = rsp_alias_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rd_en         = 1'b0;
      rd_idx        = '0;
      wr_en         = 1'b0;
      wr_idx        = '0;
      wr_data       = '0;
      add_next      = 1'b0;
      alc_next      = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en  = 1'b1;
            wr_idx = clr_ff;
            if (clr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + MAP_AW'(1);
            end
         end

         ST_IDLE: begin
            if (req_fire) begin
               op_in         = req_chan.op;
               sa_in         = req_chan.first_addr;
               ea_in         = req_chan.last_addr;
               am_in         = req_chan.alias_mask;
               sp_in         = req_chan.special_flag;
               sz_in         = req_chan.size;
               base_in       = req_chan.first_addr;
               res_status_in = 1'b0;
               res_isp_in    = 1'b0;
               res_addr_in   = '0;
               res_alias_in  = '0;
               unique case (req_chan.op)
                  bram_map_pkg::OP_ADD_RANGE: begin
                     i_in = req_chan.first_addr;
                     m_in = req_chan.alias_mask;
                     if (req_chan.last_addr < req_chan.first_addr) begin
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_ADD_RD;
                     end
                  end
                  bram_map_pkg::OP_ASSIGN_FIXED, bram_map_pkg::OP_ASSIGN_RELOC: begin
                     if (req_size_ok) begin
                        state_in = ST_CHK_START;
                     end else begin
                        res_status_in = 1'b1;
                        state_in      = ST_DONE;
                     end
                  end
                  bram_map_pkg::OP_QUERY_SPECIAL: begin
                     if (req_chan.first_addr <= lim) begin
                        rd_en    = 1'b1;
                        rd_idx   = req_chan.first_addr[MAP_AW-1:0];
                        state_in = ST_QRY_EV;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end

         // Range fill: read each in-limit address, then mark it if still free
         ST_ADD_RD: begin
            if (or_addr <= lim) begin
               rd_en    = 1'b1;
               rd_idx   = or_addr[MAP_AW-1:0];
               state_in = ST_ADD_WR;
            end else begin
               add_next = 1'b1;
            end
         end

         ST_ADD_WR: begin
            if (!rdata_ff.valid) begin
               wr_en           = 1'b1;
               wr_idx          = or_addr[MAP_AW-1:0];
               wr_data.valid   = 1'b1;
               wr_data.special = sp_ff;
               wr_data.amask   = am_ff;
               wr_data.owned   = rdata_ff.owned;
            end
            add_next = 1'b1;
         end

         // Run check: end of run must be within the limit
         ST_CHK_START: begin
            k_in = '0;
            if (addr_sum > lim_w) begin
               if (op_ff == bram_map_pkg::OP_ASSIGN_FIXED && base_ff <= lim) begin
                  rd_en    = 1'b1;
                  rd_idx   = base_ff[MAP_AW-1:0];
                  state_in = ST_SPC_EV;
               end else begin
                  res_status_in = 1'b1;
                  state_in      = ST_DONE;
               end
            end else begin
               state_in = ST_CHK_RD;
            end
         end

         ST_CHK_RD: begin
            rd_en    = 1'b1;
            rd_idx   = addr_sum[MAP_AW-1:0];
            state_in = ST_CHK_EV;
         end

         ST_CHK_EV: begin
            if (!rdata_ff.valid || rdata_ff.owned || rdata_ff.special) begin
               if (op_ff == bram_map_pkg::OP_ASSIGN_FIXED) begin
                  // fixed address may still land on a special register
                  rd_en    = 1'b1;
                  rd_idx   = base_ff[MAP_AW-1:0];
                  state_in = ST_SPC_EV;
               end else if (base_ff == lim) begin
                  res_status_in = 1'b1;
                  state_in      = ST_DONE;
               end else begin
                  base_in  = base_ff + ADDR_W'(1);
                  state_in = ST_CHK_START;
               end
            end else if ((k_ff + SIZE_W'(1)) == sz_ff) begin
               state_in = ST_ALC_BASE;
            end else begin
               k_in     = k_ff + SIZE_W'(1);
               state_in = ST_CHK_RD;
            end
         end

         ST_SPC_EV: begin
            if (rdata_ff.special) begin
               state_in = ST_ALC_BASE;
            end else begin
               res_status_in = 1'b1;
               state_in      = ST_DONE;
            end
         end

         // Allocation: fetch alias of the base, then mark bytes and mirrors
         ST_ALC_BASE: begin
            rd_en    = 1'b1;
            rd_idx   = base_ff[MAP_AW-1:0];
            state_in = ST_ALC_AM;
         end

         ST_ALC_AM: begin
            amask_in = rdata_ff.amask;
            m_in     = rdata_ff.amask;
            k_in     = '0;
            state_in = ST_ALC_RD;
         end

         ST_ALC_RD: begin
            if (addr_sum <= lim_w) begin
               rd_en    = 1'b1;
               rd_idx   = addr_sum[MAP_AW-1:0];
               state_in = ST_ALC_WR;
            end else begin
               alc_next = 1'b1;
            end
         end

         ST_ALC_WR: begin
            wr_en         = 1'b1;
            wr_idx        = addr_sum[MAP_AW-1:0];
            wr_data       = rdata_ff;
            wr_data.owned = 1'b1;
            alc_next      = 1'b1;
         end

         ST_QRY_EV: begin
            res_isp_in = rdata_ff.special;
            state_in   = ST_DONE;
         end

         // Hand the result to the output register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_isp_in    = res_isp_ff;
               rsp_addr_in   = res_addr_ff;
               rsp_alias_in  = res_alias_ff;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      // Range fill stepping: addresses inner, mirror masks outer
      if (add_next) begin
         if (i_ff == ea_ff) begin
            if (m_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               m_in     = m_ff & (m_ff - ADDR_W'(1));
               i_in     = sa_ff;
               state_in = ST_ADD_RD;
            end
         end else begin
            i_in     = i_ff + ADDR_W'(1);
            state_in = ST_ADD_RD;
         end
      end

      // Allocation stepping: mirror masks inner, byte offsets outer
      if (alc_next) begin
         if (m_ff == '0) begin
            if ((k_ff + SIZE_W'(1)) == sz_ff) begin
               res_addr_in  = base_ff;
               res_alias_in = amask_ff;
               state_in     = ST_DONE;
            end else begin
               k_in     = k_ff + SIZE_W'(1);
               m_in     = amask_ff;
               state_in = ST_ALC_RD;
            end
         end else begin
            m_in     = m_ff & (m_ff - ADDR_W'(1));
            state_in = ST_ALC_RD;
         end
      end
   end

   // Register write
   assign max_addr_in = csr_chan.valid ? csr_chan.data : max_addr_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         max_addr_ff  <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         max_addr_ff  <= max_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      sa_ff         <= sa_in;
      ea_ff         <= ea_in;
      am_ff         <= am_in;
      sp_ff         <= sp_in;
      sz_ff         <= sz_in;
      base_ff       <= base_in;
      i_ff          <= i_in;
      m_ff          <= m_in;
      k_ff          <= k_in;
      amask_ff      <= amask_in;
      res_status_ff <= res_status_in;
      res_isp_ff    <= res_isp_in;
      res_addr_ff   <= res_addr_in;
      res_alias_ff  <= res_alias_in;
      rsp_status_ff <= rsp_status_in;
      rsp_isp_ff    <= rsp_isp_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_alias_ff  <= rsp_alias_in;
   end

   // Map RAM: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= map_mem[rd_idx];
      end
   end

   // Map updates outside the clearing pass stay within the limit
   a_write_in_limit: assert property (@(posedge clock) disable iff (reset)
      (wr_en && state_ff != ST_CLEAR) |-> (CALC_W'(wr_idx) <= lim_w))
      else $error("map write beyond address limit");

   // Range fill never overwrites an entry that is already valid
   a_fill_only_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD_WR && wr_en) |-> !rdata_ff.valid)
      else $error("range fill rewrote a valid entry");

   // A failed allocation reports no address and no alias
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status) |->
      (rsp_chan.result_address == '0 && rsp_chan.mapped_alias == '0))
      else $error("failed allocation carries address or alias");

   // An accepted item always starts work
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != ST_IDLE))
      else $error("accepted item did not leave idle");

   // No result shows while the map is being cleared
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_chan.valid)
      else $error("result valid during clearing pass");

endmodule

### tb/sv/tb_banked_ram_map_allocator.sv
// Self-checking testbench for banked_ram_map_allocator: directed and random operations
// against an in-bench map predictor, under several idle/stall mixes and max_address values.
// Depends on bram_map_pkg and the channel interfaces in bram_map_if.sv.
module tb_banked_ram_map_allocator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int OP_W        = bram_map_pkg::OP_W;
   localparam int ADDR_W      = bram_map_pkg::ADDR_W;
   localparam int SIZE_W      = bram_map_pkg::SIZE_W;
   localparam int PERIOD      = 20;
   localparam int MAP_DEPTH   = 512;
   localparam int MAX_RUN     = 8;
   localparam int CYCLE_LIMIT = 100_000_000;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [ADDR_W-1:0] start_addr;
      logic [ADDR_W-1:0] end_addr;
      logic [ADDR_W-1:0] mirror;
      logic              sfr;
      logic [SIZE_W-1:0] size;
   } map_request_type;

   typedef struct packed {
      logic              status;
      logic [ADDR_W-1:0] base_address;
      logic              is_special;
      logic [ADDR_W-1:0] stored_mask;
   } map_reply_type;

   logic clock = 1'b0;
   logic reset;

   bram_map_req_if req_bus ();
   bram_map_rsp_if rsp_bus ();
   bram_map_csr_if csr_bus ();

   banked_ram_map_allocator dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always #(PERIOD/2) clock = ~clock;

   // Predicted map state; max_address is 9 bits so it is also the effective limit
   bit              map_valid   [MAP_DEPTH];
   bit              map_special [MAP_DEPTH];
   bit [ADDR_W-1:0] map_alias   [MAP_DEPTH];
   bit              map_owned   [MAP_DEPTH];
   int unsigned     map_top = 511;

   map_reply_type awaited_replies [$];
   int            error_count = 0;
   int            send_idle_pct = 0;
   int            reply_stall_pct = 0;
   int unsigned   last_sfr_addr = 32;

   task automatic log_mismatch(input string msg);
      $display("%0t: mismatch: %s", $time, msg);
      error_count++;
   endtask

   // Declare start..last as RAM for every mirror mask, from mask down to zero
   function automatic void fill_range(int unsigned first, int unsigned last,
                                      bit [ADDR_W-1:0] mask, bit sfr);
      int unsigned m, i, a;
      m = 32'(mask);
      while (1) begin
         for (i = first; i <= last; i++) begin
            a = i | m;
            if (a <= map_top && !map_valid[a]) begin
               map_valid[a]   = 1'b1;
               map_alias[a]   = mask;
               map_special[a] = sfr;
            end
         end
         if (m == 0) break;
         m = m & (m - 1);
      end
   endfunction

   function automatic bit run_is_free(int unsigned base, int unsigned n);
      int unsigned k;
      if (base + n - 1 > map_top) return 1'b0;
      for (k = 0; k < n; k++) begin
         if (!map_valid[base+k] || map_owned[base+k] || map_special[base+k]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Mark the run and its mirrors (base + mask + offset, a sum) as owned
   function automatic bit [ADDR_W-1:0] claim_run(int unsigned base, int unsigned n);
      int unsigned     k, m, a;
      bit [ADDR_W-1:0] mask;
      mask = map_alias[base];
      for (k = 0; k < n; k++) begin
         m = 32'(mask);
         while (1) begin
            a = base + m + k;
            if (a <= map_top) map_owned[a] = 1'b1;
            if (m == 0) break;
            m = m & (m - 1);
         end
      end
      return mask;
   endfunction

   function automatic map_reply_type predict_map_reply(map_request_type rq);
      map_reply_type r;
      int unsigned   b;
      bit            size_ok;
      r = '0;
      size_ok = (rq.size >= 1) && (rq.size <= MAX_RUN);
      case (rq.op)
         bram_map_pkg::OP_ADD_RANGE: begin
            fill_range(rq.start_addr, rq.end_addr, rq.mirror, rq.sfr);
         end
         bram_map_pkg::OP_ASSIGN_FIXED: begin
            if (size_ok && (run_is_free(rq.start_addr, rq.size) ||
                (rq.start_addr <= map_top && map_special[rq.start_addr]))) begin
               r.stored_mask  = claim_run(rq.start_addr, rq.size);
               r.base_address = rq.start_addr;
            end else begin
               r.status = 1'b1;
            end
         end
         bram_map_pkg::OP_ASSIGN_RELOC: begin
            r.status = 1'b1;
            if (size_ok) begin
               for (b = rq.start_addr; b <= map_top; b++) begin
                  if (run_is_free(b, rq.size)) begin
                     r.stored_mask  = claim_run(b, rq.size);
                     r.base_address = ADDR_W'(b);
                     r.status       = 1'b0;
                     break;
                  end
               end
            end
         end
         bram_map_pkg::OP_QUERY_SPECIAL: begin
            r.is_special = (rq.start_addr <= map_top) && map_special[rq.start_addr];
         end
      endcase
      return r;
   endfunction

   function automatic map_request_type make_request(logic [OP_W-1:0] op, int unsigned sa,
                                                    int unsigned ea, int unsigned mask,
                                                    bit sfr, int unsigned size);
      map_request_type rq;
      rq.op         = op;
      rq.start_addr = ADDR_W'(sa);
      rq.end_addr   = ADDR_W'(ea);
      rq.mirror     = ADDR_W'(mask);
      rq.sfr        = sfr;
      rq.size       = SIZE_W'(size);
      return rq;
   endfunction

   // Allocation sizes: mostly legal, a few out of range (zero or above the max)
   function automatic int unsigned pick_size(int unsigned hi);
      int unsigned k;
      if ($urandom_range(0, 99) < 5) begin
         k = $urandom_range(0, 7);
         return (k == 0) ? 0 : MAX_RUN + k;
      end
      return $urandom_range(1, hi);
   endfunction

   // Random operation mix; addresses mostly inside the current limit
   function automatic map_request_type random_request();
      map_request_type rq;
      int unsigned     pick, len;
      rq = make_request(bram_map_pkg::OP_QUERY_SPECIAL, $urandom_range(0, 511),
                        $urandom_range(0, 511), $urandom_range(0, 511),
                        1'($urandom_range(0, 1)), $urandom_range(1, 8));
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         rq.op         = bram_map_pkg::OP_ADD_RANGE;
         rq.start_addr = ADDR_W'($urandom_range(0, map_top));
         rq.sfr        = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 99) < 6) begin
            // long range (or reversed), no mirrors to keep it short
            rq.mirror = '0;
         end else begin
            len = rq.start_addr + $urandom_range(0, 7);
            rq.end_addr = (len > 511) ? ADDR_W'(511) : ADDR_W'(len);
         end
         if (rq.sfr) last_sfr_addr = rq.start_addr;
      end else if (pick < 50) begin
         rq.op = bram_map_pkg::OP_ASSIGN_FIXED;
         if ($urandom_range(0, 99) < 40) rq.start_addr = ADDR_W'(last_sfr_addr);
         else if ($urandom_range(0, 99) < 80)
            rq.start_addr = ADDR_W'($urandom_range(0, map_top));
         rq.size = SIZE_W'(pick_size(($urandom_range(0, 3) == 0) ? MAX_RUN : 3));
      end else if (pick < 75) begin
         rq.op = bram_map_pkg::OP_ASSIGN_RELOC;
         if ($urandom_range(0, 99) < 80) rq.start_addr = ADDR_W'($urandom_range(0, map_top));
         rq.size = SIZE_W'(pick_size(($urandom_range(0, 3) == 0) ? MAX_RUN : 3));
      end else if ($urandom_range(0, 1) == 0) begin
         rq.start_addr = ADDR_W'(last_sfr_addr);
      end
      return rq;
   endfunction

   // Send one item: optional idle gap, then hold valid until accepted
   task automatic drive_request(input map_request_type rq);
      int gap;
      gap = 0;
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct && gap < 50) gap++;
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
      end
      @(negedge clock);
      req_bus.op           = rq.op;
      req_bus.first_addr   = rq.start_addr;
      req_bus.last_addr    = rq.end_addr;
      req_bus.alias_mask   = rq.mirror;
      req_bus.special_flag = rq.sfr;
      req_bus.size         = rq.size;
      req_bus.valid        = 1'b1;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      awaited_replies.push_back(predict_map_reply(rq));
   endtask

   task automatic drain_replies();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (awaited_replies.size() != 0) @(posedge clock);
   endtask

   // Every item yields a reply, so an empty queue means the block is idle
   task automatic write_max_address(input int unsigned value);
      drain_replies();
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_bus.data  = ADDR_W'(value);
      csr_bus.valid = 1'b1;
      @(posedge clock);
      while (csr_bus.ready !== 1'b1) @(posedge clock);
      map_top = value;
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // Receiver side: random stalls on the reply channel
   always @(negedge clock) begin
      rsp_bus.ready = ($urandom_range(0, 99) >= reply_stall_pct);
   end

   // Reply checker: compare each accepted item against the oldest prediction
   always @(posedge clock) begin : reply_checker
      map_reply_type want;
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (awaited_replies.size() == 0) begin
            log_mismatch("reply item with nothing outstanding");
         end else begin
            want = awaited_replies.pop_front();
            if (rsp_bus.status !== want.status)
               log_mismatch($sformatf("status got %0b want %0b",
                                      rsp_bus.status, want.status));
            if (rsp_bus.result_address !== want.base_address)
               log_mismatch($sformatf("result_address got %0d want %0d",
                                      rsp_bus.result_address, want.base_address));
            if (rsp_bus.is_special !== want.is_special)
               log_mismatch($sformatf("is_special got %0b want %0b",
                                      rsp_bus.is_special, want.is_special));
            if (rsp_bus.mapped_alias !== want.stored_mask)
               log_mismatch($sformatf("mapped_alias got 0x%0h want 0x%0h",
                                      rsp_bus.mapped_alias, want.stored_mask));
         end
      end
   end

   // Nothing declared yet: queries read zero, allocations fail
   task automatic test_empty_map();
      write_max_address(127);
      drive_request(make_request(bram_map_pkg::OP_QUERY_SPECIAL, 0, 0, 0, 0, 1));
      drive_request(make_request(bram_map_pkg::OP_ASSIGN_FIXED, 5, 0, 0, 0, 1));
      drive_request(make_request(bram_map_pkg::OP_ASSIGN_RELOC, 0, 0, 0, 0, 8));
   endtask

   // Ranges with mirrors, special ranges, reversed range, range past the limit
   task automatic test_range_fill();
      drive_request(make_request(bram_map_pkg::OP_ADD_RANGE, 16, 31, 'h040, 0, 1));
      drive_request(make_request(bram_map_pkg::OP_ADD_RANGE, 32, 35, 0, 1, 1));
      drive_request(make_request(bram_map_pkg::OP_ADD_RANGE, 40, 39, 0, 1, 1));
      drive_request(make_request(bram_map_pkg::OP_ADD_RANGE, 120, 135, 0, 0, 1));
      drive_request(make_request(bram_map_pkg::OP_ADD_RANGE, 0, 0, 'h1ff, 0, 1));
      drive_request(make_request(bram_map_pkg::OP_ADD_RANGE, 511, 511, 'h1ff, 1, 15));
   endtask

   task automatic test_special_query();
      drive_request(make_request(bram_map_pkg::OP_QUERY_SPECIAL, 32, 511, 'h1ff, 1, 15));
      drive_request(make_request(bram_map_pkg::OP_QUERY_SPECIAL, 16, 0, 0, 0, 1));
      drive_request(make_request(bram_map_pkg::OP_QUERY_SPECIAL, 511, 0, 0, 0, 1));
   endtask

   // Fixed claims: clean run with mirrors, re-claim, special base, past the limit
   task automatic test_fixed_claims();
      drive_request(make_request(bram_map_pkg::OP_ASSIGN_FIXED, 16, 0, 0, 0, 4));
      drive_request(make_request(bram_map_pkg::OP_ASSIGN_FIXED, 16, 0, 0, 0, 1));
      drive_request(make_request(bram_map_pkg::OP_ASSIGN_FIXED, 32, 0, 0, 0, 8));
      drive_request(make_request(bram_map_pkg::OP_ASSIGN_FIXED, 32, 0, 0, 0, 2));
      drive_request(make_request(bram_map_pkg::OP_ASSIGN_FIXED, 511, 0, 0, 0, 1));
      drive_request(make_request(bram_map_pkg::OP_ASSIGN_FIXED, 0, 0, 0, 0, 1));
   endtask

   // Out-of-range sizes fail and leave the map alone; sender waits for all replies first
   task automatic test_size_limits();
      drain_replies();
      drive_request(make_request(bram_map_pkg::OP_ASSIGN_FIXED, 33, 0, 0, 0, 0));
      drive_request(make_request(bram_map_pkg::OP_ASSIGN_RELOC, 0, 0, 0, 0, 9));
      drive_request(make_request(bram_map_pkg::OP_ASSIGN_FIXED, 120, 0, 0, 0, 15));
   endtask

   // First-fit search, a run ending exactly at the limit, one crossing it
   task automatic test_first_fit();
      drive_request(make_request(bram_map_pkg::OP_ASSIGN_RELOC, 0, 0, 0, 0, 8));
      drive_request(make_request(bram_map_pkg::OP_ASSIGN_RELOC, 120, 0, 0, 0, 8));
      drive_request(make_request(bram_map_pkg::OP_ASSIGN_RELOC, 121, 0, 0, 0, 8));
   endtask

   task automatic test_random_traffic(input int unsigned top, input int count,
                                      input int idle_pct, input int stall_pct);
      write_max_address(top);
      send_idle_pct   = idle_pct;
      reply_stall_pct = stall_pct;
      repeat (count) drive_request(random_request());
   endtask

   initial begin
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.op           = bram_map_pkg::OP_ADD_RANGE;
      req_bus.first_addr   = '0;
      req_bus.last_addr    = '0;
      req_bus.alias_mask   = '0;
      req_bus.special_flag = 1'b0;
      req_bus.size         = '0;
      csr_bus.valid        = 1'b0;
      csr_bus.data         = '0;
      rsp_bus.ready        = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_map();
      test_range_fill();
      test_special_query();
      test_fixed_claims();
      test_size_limits();
      test_first_fit();

      test_random_traffic(511, 400, 0, 0);
      test_random_traffic(0, 100, 80, 0);
      test_random_traffic(255, 350, 0, 80);
      test_random_traffic(63, 300, 26, 26);
      test_random_traffic(400, 350, 0, 0);
      test_random_traffic(511, 300, 26, 26);

      drain_replies();
      repeat (32) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_banked_ram_map_allocator: done, clean");
      end else begin
         $display("tb_banked_ram_map_allocator: done, errors");
      end
      $finish;
   end

   // Hang guard
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb_banked_ram_map_allocator: done, errors");
      $finish;
   end

endmodule
